// ----- design/rpw_pkg.sv -----
package rpw_pkg;

    // fixed field widths
    localparam int TIME_BITS = 40;
    localparam int MAX_SLOTS = 64;
    localparam int DL_W      = 42;
    localparam int ST_W      = 24;
    localparam int NS_W      = 7;
    localparam int SEC_W     = 17;
    localparam int LVL_W     = 2;
    localparam int CMD_W     = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Q1.16 fractions
    localparam int Q_BITS = 16;
    localparam logic [SEC_W-1:0] ONE_Q16 = SEC_W'(1 << Q_BITS);

    // derived datapath widths
    localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
    localparam int N_W        = $clog2(MAX_SLOTS + 1);
    localparam int MD_W       = N_W + ST_W;
    localparam int A_W        = MD_W + N_W;
    localparam int MARGIN_W   = TIME_BITS + 1;
    localparam int LHS_W      = MARGIN_W + N_W;
    localparam int CMP_W      = LHS_W + Q_BITS;
    localparam int PROD_W     = A_W + SEC_W;
    localparam int MUL_A_W    = (MARGIN_W > A_W) ? MARGIN_W : A_W;
    localparam int MUL_B_W    = ST_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESET_RING = 2'd0,
        CMD_STEP       = 2'd1,
        CMD_POLL       = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT_TICKS     = 3'd0,
        REG_NUM_SLOTS      = 3'd1,
        REG_FIRST_SECTION  = 3'd2,
        REG_SECOND_SECTION = 3'd3,
        REG_THIRD_SECTION  = 3'd4
    } cfg_reg_t;

    localparam logic [LVL_W-1:0] LEVEL_AHEAD  = 2'd0;
    localparam logic [LVL_W-1:0] LEVEL_MILD   = 2'd1;
    localparam logic [LVL_W-1:0] LEVEL_BEHIND = 2'd2;
    localparam logic [LVL_W-1:0] LEVEL_SEVERE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_MD,
        S_UPD,
        S_GA,
        S_GB,
        S_GC,
        S_GD,
        S_GE,
        S_GF,
        S_DONE
    } state_t;

endpackage

// ----- design/realtime_pacing_watchdog_core.sv -----
// step and poll run S_MD, S_UPD and S_GA to S_GF, then give a result; when the margin
// is not positive, grading stops after S_GB; reset ring writes each active slot in S_FILL,
// and an unused command goes straight to S_DONE
// one item at a time: the next transfer is taken in the cycle after the result is loaded;
// a finished result waits in its own output register while the next item is taken
// aresetn (synchronous, active low) restores register defaults and clears the ring valid bits
module realtime_pacing_watchdog_core
    import rpw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic [TIME_BITS-1:0]     s_now_ticks,

    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [LVL_W-1:0]         m_restriction_level,
    output logic signed [DL_W-1:0]   m_deadline_ticks,

    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

    // sequencer
    state_t state_reg, state_next;

    // configuration registers
    logic [ST_W-1:0]  slot_ticks_reg;
    logic [NS_W-1:0]  num_slots_reg;
    logic [SEC_W-1:0] first_sec_reg;
    logic [SEC_W-1:0] second_sec_reg;
    logic [SEC_W-1:0] third_sec_reg;

    // watchdog state
    logic [SLOT_IDX_W-1:0]   pos_reg;
    logic [N_W-1:0]          warmup_reg;
    logic signed [DL_W-1:0]  last_ddl_reg;
    logic [LVL_W-1:0]        level_reg;

    // deadline ring, one valid bit per entry stands for the all-zero reset
    logic [DL_W-1:0]         ring_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]    ring_vld_reg;
    logic [DL_W-1:0]         rd_data_reg;

    // item registers
    cmd_t                    cmd_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic [SLOT_IDX_W-1:0]   fill_idx_reg;
    logic signed [DL_W-1:0]  fill_val_reg;

    // grading datapath
    logic [MD_W-1:0]         md_reg;
    logic [A_W-1:0]          a_reg;
    logic [LHS_W-1:0]        lhs_reg;
    logic signed [DL_W:0]    d_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [1:0]              cmp_reg;

    // output register
    logic                    m_valid_reg;
    logic [LVL_W-1:0]        m_level_reg;
    logic signed [DL_W-1:0]  m_ddl_reg;

    // combinational helpers
    logic [N_W-1:0]          n_eff;
    logic [N_W-1:0]          n_cfg_eff;
    logic [ST_W-1:0]         st_eff;
    logic [SEC_W-1:0]        sec1, sec2, sec3, sec_sel, sec_diff;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_p;
    logic                    s_xfer;
    logic                    out_load;
    logic                    cfg_hit;
    logic                    mem_we;
    logic [SLOT_IDX_W-1:0]   mem_waddr;
    logic [DL_W-1:0]         mem_wdata;
    logic signed [DL_W-1:0]  old_ddl, now_s, base_ddl, new_ddl;
    logic signed [DL_W:0]    d_next;
    logic                    d_nonpos;
    logic                    cmp_gt;
    logic [SLOT_IDX_W-1:0]   pos_step;

    function automatic logic [N_W-1:0] clamp_slots(input logic [NS_W-1:0] v);
        logic [N_W-1:0] r;
        if (v == '0) begin
            r = N_W'(1);
        end else if (N_W'(v) > N_W'(MAX_SLOTS)) begin
            r = N_W'(MAX_SLOTS);
        end else begin
            r = N_W'(v);
        end
        return r;
    endfunction

    // effective configuration: zero slot length and slot count out of range
    assign n_eff  = clamp_slots(num_slots_reg);
    assign st_eff = (slot_ticks_reg == '0) ? ST_W'(1) : slot_ticks_reg;

    // sections clamped into order, third first
    assign sec3 = (third_sec_reg > ONE_Q16) ? ONE_Q16 : third_sec_reg;
    assign sec2 = (second_sec_reg > sec3) ? sec3 : second_sec_reg;
    assign sec1 = (first_sec_reg > sec2) ? sec2 : first_sec_reg;

    // slot count that a config write leaves behind, for the ring position
    assign n_cfg_eff = (cfg_reg_t'(cfg_index) == REG_NUM_SLOTS) ?
                       clamp_slots(cfg_wdata[NS_W-1:0]) : n_eff;

    always_comb begin
        case (cfg_reg_t'(cfg_index))
            REG_SLOT_TICKS, REG_NUM_SLOTS, REG_FIRST_SECTION,
            REG_SECOND_SECTION, REG_THIRD_SECTION: cfg_hit = cfg_wr_en;
            default:                               cfg_hit = 1'b0;
        endcase
    end

    assign s_xfer   = s_valid && s_ready;
    assign pos_step = ({1'b0, pos_reg} == n_eff - N_W'(1)) ? '0 : pos_reg + SLOT_IDX_W'(1);

    // step update: min(now, old) + max delay, max delay sits in prod_reg after S_MD
    assign old_ddl  = ring_vld_reg[pos_reg] ? signed'(rd_data_reg) : '0;
    assign now_s    = signed'({{(DL_W-TIME_BITS){1'b0}}, now_reg});
    assign base_ddl = (now_s < old_ddl) ? now_s : old_ddl;
    assign new_ddl  = base_ddl + signed'({{(DL_W-MD_W){1'b0}}, prod_reg[MD_W-1:0]});

    // margin, one bit wider than a deadline
    assign d_next   = {last_ddl_reg[DL_W-1], last_ddl_reg} -
                      signed'({{(DL_W+1-TIME_BITS){1'b0}}, now_reg});
    assign d_nonpos = d_reg[DL_W] || (d_reg == '0);

    // margin * n * 2^16 against max_delay * factor * (1 - section)
    assign cmp_gt = {lhs_reg, {Q_BITS{1'b0}}} > {{(CMP_W-PROD_W){1'b0}}, prod_reg};

    // the one shared multiplier
    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    case (cmd_t'(s_cmd))
                        CMD_RESET_RING: state_next = S_FILL;
                        CMD_STEP,
                        CMD_POLL:       state_next = S_MD;
                        default:        state_next = S_DONE;
                    endcase
                end
            end
            S_FILL: begin
                if (fill_idx_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_MD:  state_next = S_UPD;
            S_UPD: state_next = S_GA;
            S_GA:  state_next = S_GB;
            S_GB:  state_next = d_nonpos ? S_DONE : S_GC;
            S_GC:  state_next = S_GD;
            S_GD:  state_next = S_GE;
            S_GE:  state_next = S_GF;
            S_GF:  state_next = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = new_ddl;
        mul_a     = '0;
        mul_b     = '0;
        sec_sel   = sec1;
        case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = fill_idx_reg;
                mem_wdata = fill_val_reg;
            end
            S_MD: begin
                // max delay = n * slot length
                mul_a = {{(MUL_A_W-N_W){1'b0}}, n_eff};
                mul_b = st_eff;
            end
            S_UPD: mem_we = (cmd_reg == CMD_STEP);
            S_GA: begin
                mul_a = {{(MUL_A_W-MD_W){1'b0}}, md_reg};
                mul_b = {{(MUL_B_W-N_W){1'b0}}, warmup_reg};
            end
            S_GB: begin
                mul_a = {{(MUL_A_W-MARGIN_W){1'b0}}, d_reg[MARGIN_W-1:0]};
                mul_b = {{(MUL_B_W-N_W){1'b0}}, n_eff};
            end
            S_GC, S_GD, S_GE: begin
                if (state_reg == S_GD) begin
                    sec_sel = sec2;
                end else if (state_reg == S_GE) begin
                    sec_sel = sec3;
                end
                mul_a = {{(MUL_A_W-A_W){1'b0}}, a_reg};
                mul_b = {{(MUL_B_W-SEC_W){1'b0}}, sec_diff};
            end
            S_DONE: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign sec_diff = ONE_Q16 - sec_sel;

    // deadline memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[pos_reg];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slot_ticks_reg <= ST_W'(1000);
            num_slots_reg  <= NS_W'(1);
            first_sec_reg  <= ONE_Q16;
            second_sec_reg <= ONE_Q16;
            third_sec_reg  <= ONE_Q16;
            pos_reg        <= '0;
            warmup_reg     <= N_W'(1);
            last_ddl_reg   <= '0;
            level_reg      <= LEVEL_AHEAD;
            ring_vld_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            // config writes are to come only while idle; the block itself does not enforce it
            if (cfg_hit) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SLOT_TICKS:     slot_ticks_reg <= cfg_wdata[ST_W-1:0];
                    REG_NUM_SLOTS:      num_slots_reg  <= cfg_wdata[NS_W-1:0];
                    REG_FIRST_SECTION:  first_sec_reg  <= cfg_wdata[SEC_W-1:0];
                    REG_SECOND_SECTION: second_sec_reg <= cfg_wdata[SEC_W-1:0];
                    REG_THIRD_SECTION:  third_sec_reg  <= cfg_wdata[SEC_W-1:0];
                    default: ;
                endcase
                ring_vld_reg <= '0;
                pos_reg      <= SLOT_IDX_W'(n_cfg_eff - N_W'(1));
                warmup_reg   <= N_W'(1);
            end

            if (s_xfer) begin
                case (cmd_t'(s_cmd))
                    CMD_RESET_RING: begin
                        pos_reg    <= SLOT_IDX_W'(n_eff - N_W'(1));
                        warmup_reg <= N_W'(1);
                    end
                    CMD_STEP: pos_reg <= pos_step;
                    default: ;
                endcase
            end

            if (mem_we) begin
                ring_vld_reg[mem_waddr] <= 1'b1;
            end

            // step writes the new deadline and bumps the warm-up factor while it is below the slot count
            if (state_reg == S_UPD && cmd_reg == CMD_STEP) begin
                last_ddl_reg <= new_ddl;
                if (warmup_reg < n_eff) begin
                    warmup_reg <= warmup_reg + N_W'(1);
                end
            end

            if (state_reg == S_GB && d_nonpos) begin
                level_reg <= LEVEL_SEVERE;
            end else if (state_reg == S_GF) begin
                if (cmp_reg[0]) begin
                    level_reg <= LEVEL_AHEAD;
                end else if (cmp_reg[1]) begin
                    level_reg <= LEVEL_MILD;
                end else if (cmp_gt) begin
                    level_reg <= LEVEL_BEHIND;
                end else begin
                    level_reg <= LEVEL_SEVERE;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and grading datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg      <= cmd_t'(s_cmd);
            now_reg      <= s_now_ticks;
            fill_idx_reg <= SLOT_IDX_W'(n_eff - N_W'(1));
            fill_val_reg <= signed'({{(DL_W-TIME_BITS){1'b0}}, s_now_ticks});
        end

        // ring fill walks down from the newest slot, one slot length apart
        if (state_reg == S_FILL) begin
            fill_idx_reg <= fill_idx_reg - SLOT_IDX_W'(1);
            fill_val_reg <= fill_val_reg - signed'({{(DL_W-ST_W){1'b0}}, st_eff});
        end

        prod_reg <= mul_p[PROD_W-1:0];

        if (state_reg == S_UPD) begin
            md_reg <= prod_reg[MD_W-1:0];
        end
        if (state_reg == S_GA) begin
            d_reg <= d_next;
        end
        if (state_reg == S_GB) begin
            a_reg <= prod_reg[A_W-1:0];
        end
        if (state_reg == S_GC) begin
            lhs_reg <= prod_reg[LHS_W-1:0];
        end
        if (state_reg == S_GD) begin
            cmp_reg[0] <= cmp_gt;
        end
        if (state_reg == S_GE) begin
            cmp_reg[1] <= cmp_gt;
        end

        if (out_load) begin
            m_level_reg <= (state_reg == S_DONE && state_next == S_IDLE) ? level_reg : m_level_reg;
            m_ddl_reg   <= last_ddl_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_restriction_level = m_level_reg;
    assign m_deadline_ticks    = m_ddl_reg;

    // ring position stays inside the active slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pos_reg} < n_eff)
        else $error("ring position beyond slot count");

    // warm-up factor runs from one up to the slot count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (warmup_reg != '0) && (warmup_reg <= n_eff))
        else $error("warm-up factor out of range");

    // ring fill only touches active slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> ({1'b0, fill_idx_reg} < n_eff))
        else $error("ring fill index beyond slot count");

    // one item at a time: no second transfer right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready)
        else $error("input taken while an item is in progress");

    // a non-positive margin always grades as most restricted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GB && d_nonpos) |=> (level_reg == LEVEL_SEVERE))
        else $error("non-positive margin not graded severe");

endmodule
